FILE: hdl/amcd_pkg.sv
// amcd_pkg: shared types and constants for the avi movi chunk demuxer
// parse phases, result kinds, beat structs and four-character codes
// no dependencies
`default_nettype none
package amcd_pkg;

  typedef enum logic [4:0] {
    PH_RIFF   = 5'd0,
    PH_T_HDR  = 5'd1,
    PH_T_TYPE = 5'd2,
    PH_T_SKIP = 5'd3,
    PH_H_HDR  = 5'd4,
    PH_H_TYPE = 5'd5,
    PH_H_SKIP = 5'd6,
    PH_S_HDR  = 5'd7,
    PH_S_STRH = 5'd8,
    PH_S_SKIP = 5'd9,
    PH_M_HDR  = 5'd10,
    PH_M_TYPE = 5'd11,
    PH_M_DATA = 5'd12,
    PH_M_SKIP = 5'd13,
    PH_R_HDR  = 5'd14,
    PH_R_DATA = 5'd15,
    PH_R_SKIP = 5'd16,
    PH_DONE   = 5'd17,
    PH_ERROR  = 5'd18
  } phase_t;

  typedef enum logic [2:0] {
    K_PAYLOAD = 3'd0,
    K_TIMING  = 3'd1,
    K_FORMAT  = 3'd2,
    K_MISSING = 3'd3,
    K_END     = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_end;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic        chunk_last;
    logic [31:0] chunk_length;
    logic [31:0] stream_rate;
    logic [31:0] stream_scale;
  } out_beat_t;

  // four-character codes, first character in the low byte
  localparam logic [31:0] FCC_RIFF = 32'h4646_4952;
  localparam logic [31:0] FCC_AVI  = 32'h2049_5641;
  localparam logic [31:0] FCC_LIST = 32'h5453_494C;
  localparam logic [31:0] FCC_HDRL = 32'h6C72_6468;
  localparam logic [31:0] FCC_STRL = 32'h6C72_7473;
  localparam logic [31:0] FCC_STRH = 32'h6872_7473;
  localparam logic [31:0] FCC_VIDS = 32'h7364_6976;
  localparam logic [31:0] FCC_MOVI = 32'h6976_6F6D;
  localparam logic [31:0] FCC_REC  = 32'h2063_6572;
  localparam logic [7:0]  CH_D = 8'h64;
  localparam logic [7:0]  CH_C = 8'h63;
  localparam logic [7:0]  CH_W = 8'h77;
  localparam logic [7:0]  CH_B = 8'h62;

endpackage
`default_nettype wire

FILE: hdl/avi_movi_chunk_demuxer_unit.sv
// avi_movi_chunk_demuxer_unit: byte-wise avi parser that extracts movi chunk payload
// depends on amcd_pkg
//
// channel | dir | handshake          | beat
// in_     | in  | in_valid/in_stall   | in_beat_t: one file byte, file end mark
// out_    | out | out_valid/out_stall | out_beat_t: payload byte or status result
// cfg_    | in  | cfg_wr_en           | wanted_audio bit
//
// one byte per cycle while in_stall is low: the whole parse step is logic between
// the state registers and a 4-entry result queue; a byte yields at most two results
// in_stall rises while the queue holds more than two beats
// out_stall only backs up the queue, parse state never waits on it
// synchronous active-low reset returns to the riff header phase, empty queue
// file end also returns all parse state to reset, wanted_audio is kept
`default_nettype none
module avi_movi_chunk_demuxer_unit
  import amcd_pkg::*;
#(
  parameter int SIZE_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_data,
  input  wire logic      cfg_wr_en,
  input  wire logic      cfg_wr_data
);

  localparam logic [31:0] SIZE_TOP = 32'hFFFF_FFFF >> (32 - SIZE_BITS);

  typedef logic [SIZE_BITS-1:0] cnt_t;

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [5:0]  fbc_r, fbc_nxt;
  logic [31:0] fcc_r, fcc_nxt;
  logic [31:0] sz_r, sz_nxt;
  cnt_t        cbl_r, cbl_nxt;
  logic        pad_r, pad_nxt;
  cnt_t        mvl_r, mvl_nxt;
  cnt_t        inl_r, inl_nxt;
  cnt_t        hdl_r, hdl_nxt;
  cnt_t        stl_r, stl_nxt;
  logic        vid_r, vid_nxt;
  logic [31:0] scl_r, scl_nxt;
  logic        seen_r, seen_nxt;
  logic        audio_r;

  // results of this step
  out_beat_t   res0, res1;
  logic [1:0]  nres;

  // result queue
  out_beat_t   q_mem [4];
  logic [1:0]  rd_ptr_r, wr_ptr_r;
  logic [2:0]  cnt_r;

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall  = (cnt_r > 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_mem[rd_ptr_r];

  function automatic out_beat_t mk(input kind_t k, input logic [7:0] b, input logic l,
                                   input logic [31:0] len, input logic [31:0] rate,
                                   input logic [31:0] scale);
    out_beat_t o;
    o.kind = k;
    o.payload_byte = b;
    o.chunk_last = l;
    o.chunk_length = len;
    o.stream_rate = rate;
    o.stream_scale = scale;
    return o;
  endfunction

  function automatic cnt_t sat_add(input cnt_t a, input logic p);
    logic [SIZE_BITS:0] s;
    s = {1'b0, a} + {{SIZE_BITS{1'b0}}, p};
    return s[SIZE_BITS] ? {SIZE_BITS{1'b1}} : s[SIZE_BITS-1:0];
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic        do_settle;
    logic        lst;
    logic        sel;
    logic [5:0]  idx;
    out_beat_t   e;
    logic        have_e;
    b = in_data.data_byte;
    phase_nxt = phase_r;
    fbc_nxt = fbc_r;
    fcc_nxt = fcc_r;
    sz_nxt = sz_r;
    cbl_nxt = cbl_r;
    pad_nxt = pad_r;
    mvl_nxt = mvl_r;
    inl_nxt = inl_r;
    hdl_nxt = hdl_r;
    stl_nxt = stl_r;
    vid_nxt = vid_r;
    scl_nxt = scl_r;
    seen_nxt = seen_r;
    res0 = '0;
    res1 = '0;
    nres = 2'd0;
    do_settle = 1'b0;
    lst = 1'b0;
    sel = 1'b0;
    idx = '0;
    e = '0;
    have_e = 1'b0;

    // list counters that this byte falls inside
    if (phase_r >= PH_H_HDR && phase_r <= PH_S_SKIP && hdl_nxt != '0) hdl_nxt = hdl_nxt - 1'b1;
    if (phase_r >= PH_S_HDR && phase_r <= PH_S_SKIP && stl_nxt != '0) stl_nxt = stl_nxt - 1'b1;
    if (phase_r >= PH_M_HDR && phase_r <= PH_R_SKIP && mvl_nxt != '0) mvl_nxt = mvl_nxt - 1'b1;
    if (phase_r >= PH_R_HDR && phase_r <= PH_R_SKIP && inl_nxt != '0) inl_nxt = inl_nxt - 1'b1;

    case (phase_r)
      PH_RIFF: begin
        if (fbc_r < 6'd4 || fbc_r >= 6'd8) fcc_nxt = {b, fcc_r[31:8]};
        if (fbc_r == 6'd3 && fcc_nxt != FCC_RIFF) begin
          e = mk(K_FORMAT, '0, 1'b0, '0, '0, '0);
          have_e = 1'b1;
          phase_nxt = PH_ERROR;
        end else if (fbc_r >= 6'd11) begin
          if (fcc_nxt != FCC_AVI) begin
            e = mk(K_FORMAT, '0, 1'b0, '0, '0, '0);
            have_e = 1'b1;
            phase_nxt = PH_ERROR;
          end else begin
            phase_nxt = PH_T_HDR;
          end
          fbc_nxt = '0;
        end else begin
          fbc_nxt = fbc_r + 6'd1;
        end
      end
      PH_T_HDR, PH_H_HDR, PH_S_HDR, PH_M_HDR, PH_R_HDR: begin
        if (fbc_r < 6'd4) fcc_nxt = {b, fcc_r[31:8]};
        else sz_nxt = {b, sz_r[31:8]};
        if (fbc_r < 6'd7) begin
          fbc_nxt = fbc_r + 6'd1;
        end else begin
          fbc_nxt = '0;
          if (sz_nxt > SIZE_TOP) sz_nxt = SIZE_TOP;
          cbl_nxt = sz_nxt[SIZE_BITS-1:0];
          pad_nxt = sz_nxt[0];
          lst = (fcc_nxt == FCC_LIST);
          if (audio_r) sel = (fcc_nxt[23:16] == CH_W) && (fcc_nxt[31:24] == CH_B);
          else sel = (fcc_nxt[23:16] == CH_D) &&
                     (fcc_nxt[31:24] == CH_C || fcc_nxt[31:24] == CH_B);
          // enter_body target and header phase
          case (phase_r)
            PH_T_HDR: begin
              if (lst) phase_nxt = PH_T_TYPE;
              else phase_nxt = PH_T_SKIP;
            end
            PH_H_HDR: begin
              if (lst) phase_nxt = PH_H_TYPE;
              else phase_nxt = PH_H_SKIP;
            end
            PH_S_HDR: begin
              if (fcc_nxt == FCC_STRH) begin
                vid_nxt = 1'b0;
                phase_nxt = PH_S_STRH;
              end else begin
                phase_nxt = PH_S_SKIP;
              end
            end
            PH_M_HDR: begin
              if (lst) phase_nxt = PH_M_TYPE;
              else phase_nxt = sel ? PH_M_DATA : PH_M_SKIP;
            end
            default: phase_nxt = sel ? PH_R_DATA : PH_R_SKIP;
          endcase
          // empty chunk goes straight back to the header phase
          if (!(lst && (phase_r == PH_T_HDR || phase_r == PH_H_HDR || phase_r == PH_M_HDR))
              && cbl_nxt == '0 && !pad_nxt) begin
            phase_nxt = phase_r;
            do_settle = 1'b1;
          end
        end
      end
      PH_T_TYPE, PH_H_TYPE, PH_M_TYPE: begin
        fcc_nxt = {b, fcc_r[31:8]};
        if (cbl_nxt != '0) cbl_nxt = cbl_nxt - 1'b1;
        if (fbc_r < 6'd3) begin
          fbc_nxt = fbc_r + 6'd1;
        end else begin
          fbc_nxt = '0;
          if (phase_r == PH_T_TYPE && fcc_nxt == FCC_HDRL) begin
            hdl_nxt = sat_add(cbl_nxt, pad_nxt);
            cbl_nxt = '0;
            pad_nxt = 1'b0;
            phase_nxt = PH_H_HDR;
            do_settle = 1'b1;
          end else if (phase_r == PH_T_TYPE && fcc_nxt == FCC_MOVI) begin
            mvl_nxt = cbl_nxt;
            seen_nxt = 1'b1;
            cbl_nxt = '0;
            pad_nxt = 1'b0;
            phase_nxt = PH_M_HDR;
            do_settle = 1'b1;
          end else if (phase_r == PH_H_TYPE && fcc_nxt == FCC_STRL) begin
            stl_nxt = sat_add(cbl_nxt, pad_nxt);
            cbl_nxt = '0;
            pad_nxt = 1'b0;
            phase_nxt = PH_S_HDR;
            do_settle = 1'b1;
          end else if (phase_r == PH_M_TYPE && fcc_nxt == FCC_REC) begin
            inl_nxt = sat_add(cbl_nxt, pad_nxt);
            cbl_nxt = '0;
            pad_nxt = 1'b0;
            phase_nxt = PH_R_HDR;
            do_settle = 1'b1;
          end else begin
            // other list types are skipped as plain chunks
            case (phase_r)
              PH_T_TYPE: phase_nxt = PH_T_SKIP;
              PH_H_TYPE: phase_nxt = PH_H_SKIP;
              default:   phase_nxt = PH_M_SKIP;
            endcase
            if (cbl_nxt == '0 && !pad_nxt) begin
              case (phase_r)
                PH_T_TYPE: phase_nxt = PH_T_HDR;
                PH_H_TYPE: phase_nxt = PH_H_HDR;
                default:   phase_nxt = PH_M_HDR;
              endcase
              do_settle = 1'b1;
            end
          end
        end
      end
      PH_T_SKIP, PH_H_SKIP, PH_S_STRH, PH_S_SKIP,
      PH_M_DATA, PH_M_SKIP, PH_R_DATA, PH_R_SKIP: begin
        if (cbl_r != '0) begin
          idx = fbc_r;
          cbl_nxt = cbl_r - 1'b1;
          if (fbc_r < 6'd63) fbc_nxt = fbc_r + 6'd1;
          if (phase_r == PH_M_DATA || phase_r == PH_R_DATA) begin
            e = mk(K_PAYLOAD, b, cbl_nxt == '0, sz_r, '0, '0);
            have_e = 1'b1;
          end else if (phase_r == PH_S_STRH) begin
            if (idx < 6'd4) begin
              fcc_nxt = {b, fcc_r[31:8]};
              if (idx == 6'd3) vid_nxt = (fcc_nxt == FCC_VIDS);
            end else if (idx >= 6'd20 && idx < 6'd24) begin
              scl_nxt = {b, scl_r[31:8]};
            end else if (idx >= 6'd24 && idx < 6'd28) begin
              fcc_nxt = {b, fcc_r[31:8]};
              // dwRate complete
              if (idx == 6'd27 && vid_r) begin
                e = mk(K_TIMING, '0, 1'b0, '0, fcc_nxt, scl_r);
                have_e = 1'b1;
              end
            end
          end
        end else begin
          pad_nxt = 1'b0;
        end
        if (cbl_nxt == '0 && !pad_nxt) begin
          case (phase_r)
            PH_T_SKIP:            phase_nxt = PH_T_HDR;
            PH_H_SKIP:            phase_nxt = PH_H_HDR;
            PH_S_STRH, PH_S_SKIP: phase_nxt = PH_S_HDR;
            PH_M_DATA, PH_M_SKIP: phase_nxt = PH_M_HDR;
            default:              phase_nxt = PH_R_HDR;
          endcase
          do_settle = 1'b1;
        end
      end
      PH_DONE, PH_ERROR: begin
      end
      default: phase_nxt = PH_ERROR;
    endcase

    if (have_e) begin
      res0 = e;
      nres = 2'd1;
    end

    // close finished lists at a chunk boundary
    if (do_settle) begin
      if (phase_nxt == PH_S_HDR && stl_nxt == '0) phase_nxt = PH_H_HDR;
      if (phase_nxt == PH_H_HDR && hdl_nxt == '0) phase_nxt = PH_T_HDR;
      if (phase_nxt == PH_R_HDR && inl_nxt == '0) phase_nxt = PH_M_HDR;
      if (phase_nxt == PH_M_HDR && mvl_nxt == '0) begin
        if (nres == 2'd0) res0 = mk(K_END, '0, 1'b0, '0, '0, '0);
        else res1 = mk(K_END, '0, 1'b0, '0, '0, '0);
        nres = nres + 2'd1;
        phase_nxt = PH_DONE;
      end
      fbc_nxt = '0;
    end

    if (in_data.file_end) begin
      if (phase_nxt == PH_RIFF) e = mk(K_FORMAT, '0, 1'b0, '0, '0, '0);
      else e = mk(seen_nxt ? K_END : K_MISSING, '0, 1'b0, '0, '0, '0);
      if (phase_nxt != PH_DONE && phase_nxt != PH_ERROR) begin
        if (nres == 2'd0) res0 = e;
        else res1 = e;
        nres = nres + 2'd1;
      end
      phase_nxt = PH_RIFF;
      fbc_nxt = '0;
      fcc_nxt = '0;
      sz_nxt = '0;
      cbl_nxt = '0;
      pad_nxt = 1'b0;
      mvl_nxt = '0;
      inl_nxt = '0;
      hdl_nxt = '0;
      stl_nxt = '0;
      vid_nxt = 1'b0;
      scl_nxt = '0;
      seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      fbc_r <= '0;
      fcc_r <= '0;
      sz_r <= '0;
      cbl_r <= '0;
      pad_r <= 1'b0;
      mvl_r <= '0;
      inl_r <= '0;
      hdl_r <= '0;
      stl_r <= '0;
      vid_r <= 1'b0;
      scl_r <= '0;
      seen_r <= 1'b0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      fbc_r <= fbc_nxt;
      fcc_r <= fcc_nxt;
      sz_r <= sz_nxt;
      cbl_r <= cbl_nxt;
      pad_r <= pad_nxt;
      mvl_r <= mvl_nxt;
      inl_r <= inl_nxt;
      hdl_r <= hdl_nxt;
      stl_r <= stl_nxt;
      vid_r <= vid_nxt;
      scl_r <= scl_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) audio_r <= 1'b0;
    else if (cfg_wr_en) audio_r <= cfg_wr_data;
  end

  // result queue: up to two writes, one read per cycle
  logic [1:0] npush;
  assign npush = in_acc ? nres : 2'd0;

  always_ff @(posedge clk) begin
    if (npush != 2'd0) q_mem[wr_ptr_r] <= res0;
    if (npush == 2'd2) q_mem[wr_ptr_r + 2'd1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + npush;
      if (out_acc) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, npush} - {2'b0, out_acc};
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("result queue overflow");
  a_file_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.file_end |=> phase_r == PH_RIFF && !seen_r)
    else $error("file end did not restart parse");
  a_stall_room: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> cnt_r <= 3'd2)
    else $error("input taken without room for two results");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 3'd0 && !in_acc |=> !out_valid)
    else $error("result shown from empty queue");

endmodule
`default_nettype wire
